FILE: design/cbhp_pkg.sv
// ----------------------------------------------------------------------------
// cbhp_pkg : shared types and constants of the closest box hit picker
// Controller states, datapath command and status structs.
// ----------------------------------------------------------------------------
`default_nettype none
package cbhp_pkg;

  localparam int CoordW = 32;
  localparam int DirW   = 18;
  localparam int DistW  = 31;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_ACC,
    ST_DONE
  } cbhp_state_t;

  typedef struct packed {
    logic       load;      // latch the request
    logic       start;     // launch the division selected by sel
    logic [2:0] sel;       // axis*2 + (0 lo plane, 1 hi plane)
    logic       fold;      // merge the quotient into entry/exit
    logic       acc;       // update the kept hit
    logic       clear;     // reset the kept hit
  } cbhp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic last;
  } cbhp_sts_t;

endpackage
`default_nettype wire

FILE: design/closest_box_hit_picker_core.sv
// ----------------------------------------------------------------------------
// closest_box_hit_picker_core : nearest ray/box hit over a pick
// Slab test per box on a shared serial divider, nearest hit kept.
// ----------------------------------------------------------------------------
//  channel | handshake        | payload
//  in_     | in_valid/stall   | box_min_*, box_max_*, entity_id, last_box
//  out_    | out_valid/stall  | hit_found, hit_entity, hit_distance
//  cfg_    | cfg_valid/ready  | cfg_index, cfg_data
//
// Each box runs six divisions, one after another, on the one-bit-per-cycle
// divider, and the next box is not taken until they are through; a box
// marked last adds a report step.
// A zero direction component skips the divider for the two divisions of its axis.
// Reset clears the kept hit and sets the ray registers to zero; no clearing pass.
// A stalled result is held; the next box is taken meanwhile, and the next
// report waits until the held result is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module closest_box_hit_picker_core
  import cbhp_pkg::*;
#(
  parameter int ID_BITS   = 16,
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [31:0]        in_box_min_x,
  input  wire logic [31:0]        in_box_min_y,
  input  wire logic [31:0]        in_box_min_z,
  input  wire logic [31:0]        in_box_max_x,
  input  wire logic [31:0]        in_box_max_y,
  input  wire logic [31:0]        in_box_max_z,
  input  wire logic [ID_BITS-1:0] in_entity_id,
  input  wire logic               in_last_box,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_hit_found,
  output logic [ID_BITS-1:0]      out_hit_entity,
  output logic [DistW-1:0]        out_hit_distance,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  localparam logic [2:0] REG_OX = 3'd0, REG_OY = 3'd1, REG_OZ = 3'd2,
                         REG_DX = 3'd3, REG_DY = 3'd4, REG_DZ = 3'd5;

  logic signed [CoordW-1:0] org_r [3];
  logic signed [DirW-1:0]   dir_r [3];
  logic signed [CoordW-1:0] bmin [3];
  logic signed [CoordW-1:0] bmax [3];
  cbhp_cmd_t cmd;
  cbhp_sts_t sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        org_r[i] <= '0; dir_r[i] <= '0;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OX: org_r[0] <= cfg_data;
        REG_OY: org_r[1] <= cfg_data;
        REG_OZ: org_r[2] <= cfg_data;
        REG_DX: dir_r[0] <= cfg_data[DirW-1:0];
        REG_DY: dir_r[1] <= cfg_data[DirW-1:0];
        REG_DZ: dir_r[2] <= cfg_data[DirW-1:0];
        default: ;
      endcase
    end
  end

  assign bmin[0] = in_box_min_x; assign bmin[1] = in_box_min_y;
  assign bmin[2] = in_box_min_z;
  assign bmax[0] = in_box_max_x; assign bmax[1] = in_box_max_y;
  assign bmax[2] = in_box_max_z;

  cbhp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts)
  );

  cbhp_dp #(.ID_BITS(ID_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .org(org_r), .dir(dir_r), .bmin(bmin), .bmax(bmax),
    .id_in(in_entity_id), .last_in(in_last_box),
    .hit_found(out_hit_found), .hit_entity(out_hit_entity),
    .hit_distance(out_hit_distance)
  );

endmodule
`default_nettype wire

FILE: design/cbhp_ctrl.sv
// ----------------------------------------------------------------------------
// cbhp_ctrl : request sequencer
// Steps the six slab divisions, then the accumulate and, for a box marked last, the report.
// ----------------------------------------------------------------------------
`default_nettype none
module cbhp_ctrl
  import cbhp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  output cbhp_cmd_t      cmd,
  input  wire cbhp_sts_t sts
);

  cbhp_state_t state_r, state_nxt;
  logic [2:0]  sel_r, sel_nxt;
  logic        ov_r, ov_nxt;
  logic        started_r, started_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; sel_r <= '0; ov_r <= 1'b0; started_r <= 1'b0;
    end else begin
      state_r <= state_nxt; sel_r <= sel_nxt; ov_r <= ov_nxt;
      started_r <= started_nxt;
    end
  end

  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r; sel_nxt = sel_r; ov_nxt = ov_r; started_nxt = started_r;
    cmd = '0; cmd.sel = sel_r;
    in_stall = 1'b1;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1; state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        sel_nxt = '0; started_nxt = 1'b0; state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (!started_r) begin
          cmd.start = 1'b1; started_nxt = 1'b1;
        end else if (!sts.div_busy) begin
          cmd.fold = 1'b1; started_nxt = 1'b0;
          if (sel_r == 3'd5) state_nxt = ST_ACC;
          else sel_nxt = sel_r + 3'd1;
        end
      end
      ST_ACC: begin
        cmd.acc = 1'b1;
        if (sts.last) state_nxt = ST_DONE;
        else state_nxt = ST_IDLE;
      end
      ST_DONE: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1; cmd.clear = 1'b1; state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && state_nxt == ST_IDLE) |=> out_valid)
    else $error("result not raised after report");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall)
    else $error("request taken while busy");
  a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (sel_r <= 3'd5))
    else $error("division index out of range");

endmodule
`default_nettype wire

FILE: design/cbhp_div.sv
// ----------------------------------------------------------------------------
// cbhp_div : iterative restoring divider
// Unsigned magnitude division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module cbhp_div #(
  parameter int NW = 49,
  parameter int DW = 17
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               busy,
  output logic [NW-1:0]      quo
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] d_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW:0]   sh;

  assign busy = (cnt_r != '0);
  assign quo  = q_r;
  assign sh   = {rem_r[DW-1:0], q_r[NW-1]};

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; cnt_nxt = cnt_r;
    if (start) begin
      q_nxt = num; rem_nxt = '0; cnt_nxt = CW'(NW);
    end else if (busy) begin
      cnt_nxt = cnt_r - 1'b1;
      if (sh >= {1'b0, d_r}) begin
        rem_nxt = sh - {1'b0, d_r}; q_nxt = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = sh; q_nxt = {q_r[NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
    q_r <= q_nxt; rem_r <= rem_nxt;
    if (start) d_r <= den;
  end

endmodule
`default_nettype wire

FILE: design/cbhp_dp.sv
// ----------------------------------------------------------------------------
// cbhp_dp : slab datapath
// Holds the box, runs the slab divisions and keeps the nearest hit.
// ----------------------------------------------------------------------------
`default_nettype none
module cbhp_dp
  import cbhp_pkg::*;
#(
  parameter int ID_BITS   = 16,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire cbhp_cmd_t                cmd,
  output cbhp_sts_t                     sts,
  input  wire logic signed [CoordW-1:0] org [3],
  input  wire logic signed [DirW-1:0]   dir [3],
  input  wire logic signed [CoordW-1:0] bmin [3],
  input  wire logic signed [CoordW-1:0] bmax [3],
  input  wire logic [ID_BITS-1:0]       id_in,
  input  wire logic                     last_in,
  output logic                          hit_found,
  output logic [ID_BITS-1:0]            hit_entity,
  output logic [DistW-1:0]              hit_distance
);

  localparam int NW = 33 + FRAC_BITS;
  localparam int DMW = DirW;
  localparam int TW = NW + 2;   // signed slab distance

  logic signed [CoordW-1:0] mn_r [3];
  logic signed [CoordW-1:0] mx_r [3];
  logic [ID_BITS-1:0]       id_r;
  logic                     last_r;
  logic signed [TW-1:0]     ent_r, ext_r, t0_r;
  logic                     miss_r;
  logic                     any_r;
  logic [DistW-1:0]         best_r;
  logic [ID_BITS-1:0]       bid_r;
  logic                     of_r;
  logic [ID_BITS-1:0]       oe_r;
  logic [DistW-1:0]         od_r;

  logic [1:0]               ax;
  logic signed [CoordW:0]   diff;
  logic signed [DirW-1:0]   d;
  logic [NW-1:0]            nmag;
  logic [DMW-1:0]           dmag;
  logic                     neg_r;
  logic                     busy;
  logic [NW-1:0]            quo;
  logic signed [TW-1:0]     tq, tn, tf, t;
  logic [DistW-1:0]         ts;
  logic                     hit;

  assign ax   = cmd.sel[2:1];
  assign d    = dir[ax];
  assign diff = (cmd.sel[0] ? {mx_r[ax][CoordW-1], mx_r[ax]}
                            : {mn_r[ax][CoordW-1], mn_r[ax]})
              - {org[ax][CoordW-1], org[ax]};
  assign nmag = {(diff[CoordW] ? 33'(-diff) : 33'(diff)), {FRAC_BITS{1'b0}}};
  assign dmag = d[DirW-1] ? DMW'(-d) : DMW'(d);

  cbhp_div #(.NW(NW), .DW(DMW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.start && d != '0),
    .num(nmag), .den(dmag), .busy(busy), .quo(quo)
  );

  assign sts.div_busy = busy;
  assign sts.last     = last_r;

  assign tq = neg_r ? -TW'({2'b00, quo}) : TW'({2'b00, quo});
  assign tn = (t0_r < tq) ? t0_r : tq;
  assign tf = (t0_r < tq) ? tq : t0_r;

  assign hit = !miss_r && ext_r >= 0 && ent_r <= ext_r;
  assign t   = (ent_r >= 0) ? ent_r : ext_r;
  assign ts  = (t > TW'(32'h7FFFFFFF)) ? {DistW{1'b1}} : DistW'(t);

  assign hit_found    = of_r;
  assign hit_entity   = oe_r;
  assign hit_distance = od_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < 3; i++) begin
        mn_r[i] <= bmin[i]; mx_r[i] <= bmax[i];
      end
      id_r <= id_in; last_r <= last_in;
      ent_r <= -(TW'(1) <<< (TW-2)); ext_r <= TW'(1) <<< (TW-2);
      miss_r <= (bmin[0] > bmax[0]) || (bmin[1] > bmax[1]) || (bmin[2] > bmax[2]);
    end
    if (cmd.start) neg_r <= diff[CoordW] ^ d[DirW-1];
    if (cmd.fold) begin
      if (d == '0) begin
        if (cmd.sel[0] == 1'b0 &&
            !(mn_r[ax] <= org[ax] && org[ax] <= mx_r[ax]))
          miss_r <= 1'b1;
      end else if (cmd.sel[0] == 1'b0) begin
        t0_r <= tq;
      end else begin
        if (tn > ent_r) ent_r <= tn;
        if (tf < ext_r) ext_r <= tf;
      end
    end
    if (cmd.clear) begin
      of_r <= any_r; oe_r <= any_r ? bid_r : '0; od_r <= any_r ? best_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      any_r <= 1'b0; best_r <= {DistW{1'b1}}; bid_r <= '0;
    end else if (cmd.acc && hit && (!any_r || ts < best_r)) begin
      any_r <= 1'b1; best_r <= ts; bid_r <= id_r;
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !busy) else $error("divider restarted while busy");
  a_fold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fold |-> !busy) else $error("quotient taken early");
  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> !any_r) else $error("kept hit not cleared");

endmodule
`default_nettype wire

FILE: bench/cbhp_ray_regs_pkg.sv
// ----------------------------------------------------------------------------
// cbhp_ray_regs_pkg : ray register map of the closest box hit picker bench
// Register indexes shared by the stimulus top and the checker.
// ----------------------------------------------------------------------------
package cbhp_ray_regs_pkg;

  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_DIR_X    = 3'd3,
    REG_DIR_Y    = 3'd4,
    REG_DIR_Z    = 3'd5,
    REG_SPARE_6  = 3'd6,
    REG_SPARE_7  = 3'd7
  } ray_reg_t;

endpackage

FILE: bench/cbhp_pick_checker.sv
// ----------------------------------------------------------------------------
// cbhp_pick_checker : predicts and checks the pick results
// Tracks ray register writes, runs a slab test on every accepted box request,
// keeps the nearest hit per pick and compares each reported pick in order.
// ----------------------------------------------------------------------------
module cbhp_pick_checker
  import cbhp_pkg::*;
  import cbhp_ray_regs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [31:0]       in_box_min_x,
  input  logic [31:0]       in_box_min_y,
  input  logic [31:0]       in_box_min_z,
  input  logic [31:0]       in_box_max_x,
  input  logic [31:0]       in_box_max_y,
  input  logic [31:0]       in_box_max_z,
  input  logic [15:0]       in_entity_id,
  input  logic              in_last_box,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              out_hit_found,
  input  logic [15:0]       out_hit_entity,
  input  logic [DistW-1:0]  out_hit_distance,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  output int                errors,
  output int                waiting
);

  localparam longint DistMax = 64'h7FFF_FFFF;
  localparam longint TInf    = 64'sh4000_0000_0000_0000;

  typedef struct {
    logic             found;
    logic [15:0]      entity;
    logic [DistW-1:0] distance;
  } pick_t;

  pick_t        picks_due[$];
  logic signed [31:0] org [3];
  logic signed [17:0] dir [3];
  logic [DistW-1:0]   best_dist;
  logic [15:0]        best_id;
  logic               any_hit;

  function automatic longint slab_dist(longint num, longint den);
    longint unsigned nm, dm, q;
    nm = (num < 0) ? -num : num;
    dm = (den < 0) ? -den : den;
    q  = (nm << 16) / dm;
    return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
  endfunction

  task automatic take_box();
    longint lo [3], hi [3];
    longint enter, leave, t0, t1, t, o, d;
    logic   ok;
    lo[0] = $signed(in_box_min_x); hi[0] = $signed(in_box_max_x);
    lo[1] = $signed(in_box_min_y); hi[1] = $signed(in_box_max_y);
    lo[2] = $signed(in_box_min_z); hi[2] = $signed(in_box_max_z);
    enter = -TInf;
    leave = TInf;
    ok = 1'b1;
    for (int a = 0; a < 3; a++) begin
      if (lo[a] > hi[a]) ok = 1'b0;
    end
    for (int a = 0; a < 3 && ok; a++) begin
      o = org[a];
      d = dir[a];
      if (d == 0) begin
        if (!(lo[a] <= o && o <= hi[a])) ok = 1'b0;
      end else begin
        t0 = slab_dist(lo[a] - o, d);
        t1 = slab_dist(hi[a] - o, d);
        if (((t0 < t1) ? t0 : t1) > enter) enter = (t0 < t1) ? t0 : t1;
        if (((t0 < t1) ? t1 : t0) < leave) leave = (t0 < t1) ? t1 : t0;
      end
    end
    if (ok && leave >= 0 && enter <= leave) begin
      t = (enter >= 0) ? enter : leave;
      if (t > DistMax) t = DistMax;
      if (!any_hit || t[DistW-1:0] < best_dist) begin
        any_hit   = 1'b1;
        best_dist = t[DistW-1:0];
        best_id   = in_entity_id;
      end
    end
    if (in_last_box) begin
      picks_due.push_back('{any_hit, any_hit ? best_id : 16'd0,
                            any_hit ? best_dist : '0});
      best_dist = '1;
      best_id   = '0;
      any_hit   = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    pick_t want;
    if (!rst_n) begin
      picks_due.delete();
      foreach (org[a]) org[a] = '0;
      foreach (dir[a]) dir[a] = '0;
      best_dist = '1;
      best_id   = '0;
      any_hit   = 1'b0;
      errors    = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (picks_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected pick result: found %0b id %0d dist %0d",
                     out_hit_found, out_hit_entity, out_hit_distance);
        end else begin
          want = picks_due.pop_front();
          if (want.found !== out_hit_found || want.entity !== out_hit_entity ||
              want.distance !== out_hit_distance) begin
            errors++;
            if (errors <= 10)
              $display("pick mismatch: exp found %0b id %0d dist %0d, got %0b %0d %0d",
                       want.found, want.entity, want.distance,
                       out_hit_found, out_hit_entity, out_hit_distance);
          end
        end
      end
      if (in_valid && !in_stall) take_box();
      if (cfg_valid && cfg_ready) begin
        case (ray_reg_t'(cfg_index))
          REG_ORIGIN_X: org[0] = cfg_data;
          REG_ORIGIN_Y: org[1] = cfg_data;
          REG_ORIGIN_Z: org[2] = cfg_data;
          REG_DIR_X:    dir[0] = cfg_data[17:0];
          REG_DIR_Y:    dir[1] = cfg_data[17:0];
          REG_DIR_Z:    dir[2] = cfg_data[17:0];
          default: ;
        endcase
      end
    end
    waiting = picks_due.size();
  end

endmodule

FILE: bench/tb_closest_box_hit_picker_core.sv
// ----------------------------------------------------------------------------
// tb_closest_box_hit_picker_core : bench top of the closest box hit picker
// Drives ray settings and box picks (directed corner cases, then random picks
// under several idle and stall mixes) and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_closest_box_hit_picker_core;
  import cbhp_pkg::*;
  import cbhp_ray_regs_pkg::*;

  localparam int     Limit   = 4_000_000;
  localparam int     Settle  = 400;
  localparam longint IntMax  = 64'sh7FFF_FFFF;
  localparam longint IntMin  = -64'sh8000_0000;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid, in_stall, in_last_box;
  logic [31:0]       in_box_min_x, in_box_min_y, in_box_min_z;
  logic [31:0]       in_box_max_x, in_box_max_y, in_box_max_z;
  logic [15:0]       in_entity_id;
  logic              out_valid, out_stall, out_hit_found;
  logic [15:0]       out_hit_entity;
  logic [DistW-1:0]  out_hit_distance;
  logic              cfg_valid, cfg_ready;
  logic [2:0]        cfg_index;
  logic [31:0]       cfg_data;
  int                errors, waiting, cycles;
  int                idle_pct, stall_pct;
  longint            ray_org [3];
  longint            ray_dir [3];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  closest_box_hit_picker_core dut (.*);

  cbhp_pick_checker u_checker (.*);

  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < stall_pct);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= Limit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic longint clamp32(longint v);
    return (v > IntMax) ? IntMax : (v < IntMin) ? IntMin : v;
  endfunction

  task automatic write_reg(ray_reg_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_ray(longint ox, longint oy, longint oz,
                         logic [17:0] dx, logic [17:0] dy, logic [17:0] dz);
    write_reg(REG_ORIGIN_X, ox[31:0]);
    write_reg(REG_ORIGIN_Y, oy[31:0]);
    write_reg(REG_ORIGIN_Z, oz[31:0]);
    write_reg(REG_DIR_X, {{14{dx[17]}}, dx});
    write_reg(REG_DIR_Y, {{14{dy[17]}}, dy});
    write_reg(REG_DIR_Z, {{14{dz[17]}}, dz});
    cfg_valid <= 1'b0;
    ray_org = '{ox, oy, oz};
    ray_dir = '{$signed(dx), $signed(dy), $signed(dz)};
  endtask

  task automatic send_box(longint mnx, longint mny, longint mnz,
                          longint mxx, longint mxy, longint mxz,
                          logic [15:0] id, logic last);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_box_min_x <= mnx[31:0];
    in_box_min_y <= mny[31:0];
    in_box_min_z <= mnz[31:0];
    in_box_max_x <= mxx[31:0];
    in_box_max_y <= mxy[31:0];
    in_box_max_z <= mxz[31:0];
    in_entity_id <= id;
    in_last_box  <= last;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (Settle) @(posedge clk);
  endtask

  task automatic random_box(logic last);
    longint c [3], h [3], mn [3], mx [3], t;
    int kind;
    kind = $urandom_range(0, 99);
    t = longint'($urandom_range(0, 1 << 22)) - (1 << 19);
    for (int a = 0; a < 3; a++) begin
      if (kind < 70)
        c[a] = ray_org[a] + ((ray_dir[a] * t) >>> 16);
      else
        c[a] = ray_org[a] + longint'($urandom_range(0, 1 << 22)) - (1 << 21);
      h[a] = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 1 << 20);
      mn[a] = clamp32(c[a] - h[a]);
      mx[a] = clamp32(c[a] + h[a]);
      if (kind >= 90) begin
        mn[a] = $signed($urandom());
        mx[a] = $signed($urandom());
      end
    end
    if (kind >= 85 && kind < 90) begin
      mn[0] = mx[0] + 1;
      if (mn[0] > IntMax) mn[0] = IntMax;
    end
    send_box(mn[0], mn[1], mn[2], mx[0], mx[1], mx[2], 16'($urandom()), last);
  endtask

  initial begin
    int items, len;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_box_min_x <= '0; in_box_min_y <= '0; in_box_min_z <= '0;
    in_box_max_x <= '0; in_box_max_y <= '0; in_box_max_z <= '0;
    in_entity_id <= '0;
    in_last_box  <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= REG_ORIGIN_X;
    cfg_data     <= '0;
    out_stall    = 1'b0;
    cycles       = 0;
    idle_pct     = 0;
    stall_pct    = 0;
    ray_org      = '{0, 0, 0};
    ray_dir      = '{0, 0, 0};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero ray after reset: origin inside means a saturated hit
    send_box(-100, -100, -100, 100, 100, 100, 16'd7, 1'b0);
    send_box(0, 0, 0, 0, 0, 0, 16'd9, 1'b1);
    send_box(1, 0, 0, 5, 0, 0, 16'd3, 1'b1);
    send_box(IntMin, IntMin, IntMin, IntMax, IntMax, IntMax, 16'hFFFF, 1'b1);
    send_box(5, 0, 0, 1, 0, 0, 16'd4, 1'b1);
    drain();

    write_reg(REG_SPARE_6, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_7, 32'h1234_5678);
    set_ray(0, 0, 0, 18'h10000, 18'h0, 18'h0);
    send_box(10 << 16, -1, -1, 20 << 16, 1, 1, 16'd11, 1'b0);
    send_box(10 << 16, -5, -5, 30 << 16, 5, 5, 16'd12, 1'b0);
    send_box(-20 << 16, -1, -1, -10 << 16, 1, 1, 16'd13, 1'b1);
    send_box(-5, -5, -5, 7 << 16, 5, 5, 16'd14, 1'b0);
    send_box(2 << 16, 1, -5, 3 << 16, 5, 5, 16'd15, 1'b0);
    send_box(IntMin, IntMin, IntMin, IntMax, IntMax, IntMax, 16'd0, 1'b1);
    drain();

    set_ray(IntMax, IntMin, IntMin, 18'h30000, 18'h10000, 18'h20000);
    send_box(IntMin, IntMin, IntMin, IntMax, IntMax, IntMax, 16'd21, 1'b0);
    send_box(IntMin, IntMin, IntMin, IntMin, IntMin, IntMin, 16'd22, 1'b0);
    send_box(IntMax, IntMax, IntMax, IntMax, IntMax, IntMax, 16'd23, 1'b1);
    drain();
    set_ray(0, 0, 0, 18'h00001, 18'h00001, 18'h00001);
    send_box(IntMax - 1, IntMax - 1, IntMax - 1, IntMax, IntMax, IntMax, 16'd24, 1'b0);
    send_box(IntMax - 1, IntMax - 1, IntMax - 1, IntMax, IntMax, IntMax, 16'd25, 1'b1);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 58; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 58; end
        default: begin idle_pct = 30; stall_pct = 30; end
      endcase
      case (ph)
        0: set_ray(0, 0, 0, 18'h10000, 18'h0, 18'h0);
        1: set_ray(IntMax, IntMin, 0, 18'h30000, 18'h10000, 18'h30000);
        2: set_ray($signed($urandom_range(0, 1 << 23)) - (1 << 22), 0, 0,
                   18'h0, 18'($urandom()), 18'h0);
        3: set_ray(0, 0, 0, 18'($urandom()), 18'($urandom()), 18'($urandom()));
        default: set_ray(longint'($urandom_range(0, 1 << 24)) - (1 << 23),
                         longint'($urandom_range(0, 1 << 24)) - (1 << 23),
                         $signed($urandom()),
                         18'($urandom_range(0, 1 << 17) - (1 << 16)),
                         18'($urandom_range(0, 1 << 17) - (1 << 16)),
                         18'($urandom_range(0, 1 << 17) - (1 << 16)));
      endcase
      items = 0;
      while (items < 144) begin
        len = $urandom_range(1, 6);
        for (int k = 1; k <= len; k++) random_box(k == len);
        items += len;
      end
      if (ph % 2 == 1) idle_pct = 0;
      drain();
    end

    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: sim.f
design/cbhp_pkg.sv
design/cbhp_ctrl.sv
design/cbhp_div.sv
design/cbhp_dp.sv
design/closest_box_hit_picker_core.sv
bench/cbhp_ray_regs_pkg.sv
bench/cbhp_pick_checker.sv
bench/tb_closest_box_hit_picker_core.sv
